FILE: design/tbce_pkg.sv
// ============================================================================
// tbce_pkg: shared types and codes of the text buffer cursor editor
// Command and response beat layouts, command codes and sequencer states.
// ============================================================================
package tbce_pkg;

    // Command codes carried in the mode field.
    localparam logic [2:0] MODE_LEFT   = 3'd0;
    localparam logic [2:0] MODE_RIGHT  = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_CUT    = 3'd3;
    localparam logic [2:0] MODE_COPY   = 3'd4;
    localparam logic [2:0] MODE_PASTE  = 3'd5;
    localparam logic [2:0] MODE_READ   = 3'd6;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] char_in;
        logic [8:0] count;
        logic [9:0] index;
    } cmd_t;

    typedef struct packed {
        logic        status;
        logic [10:0] cursor_pos;
        logic [10:0] text_length;
        logic [8:0]  clip_length;
        logic [7:0]  read_char;
        logic        read_valid;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_COPY,
        ST_FINISH
    } state_t;

    // Where the copy engine sends each character it reads.
    typedef enum logic [1:0] {
        DST_TEXT,
        DST_CLIP,
        DST_RESULT
    } dst_t;

endpackage

FILE: design/tbce_ram.sv
// ============================================================================
// tbce_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ============================================================================
module tbce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/text_buffer_cursor_editor_top.sv
// ============================================================================
// text_buffer_cursor_editor_top: bounded text editor with cursor and clipboard
// Gap buffer text memory, clipboard memory and a one-character-per-cycle
// copy engine under a small sequencer.
// ============================================================================
// Usage. A command beat is taken at a rising edge where start is high and
// busy is low; cmd carries mode, char_in, count and index. Every command
// gives exactly one response beat on rsp, marked by done for one cycle.
// The receiver cannot hold a response off, and none is needed: done is a
// single-cycle strobe and busy is already low in that cycle, so the next
// command may be taken at the same edge that takes the response.
//
// Copy engine. It moves one character for a cursor move that is not stopped
// at an end and for a read inside the text, the characters taken by cut or
// copy (at most CLIP_CAP), the clipboard length for a paste that fits, and
// none for everything else. It reads one character per cycle through the
// single read port of each memory and writes it in the cycle after. The
// next command may follow a response at once.
//
// Reset. Cursor, text length and clipboard length clear at once; there is
// no clearing pass, as no command reads a text or clipboard entry that was
// never written. The block is ready as soon as reset is released.
module text_buffer_cursor_editor_top #(
    parameter int TEXT_CAP = 1024,
    parameter int CLIP_CAP = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  tbce_pkg::cmd_t cmd,
    output logic           busy,
    output logic           done,
    output tbce_pkg::rsp_t rsp
);

    // Widths: counts that must also hold the capacity, and memory addresses.
    localparam int TW = $clog2(TEXT_CAP + 1);
    localparam int TA = $clog2(TEXT_CAP);
    localparam int CW = $clog2(CLIP_CAP + 1);
    localparam int CA = (CLIP_CAP > 1) ? $clog2(CLIP_CAP) : 1;
    localparam int PW = (TW > CA) ? TW : CA;

    // Sequencer state.
    tbce_pkg::state_t state_reg, state_next;

    // Editor state: cursor, text length and clipboard length.
    logic [TW-1:0] cursor_reg, cursor_next;
    logic [TW-1:0] len_reg, len_next;
    logic [CW-1:0] clip_reg, clip_next;

    // The command under way.
    tbce_pkg::cmd_t cmd_reg;

    // Copy engine: read pointer, write pointer, characters left to read.
    logic [PW-1:0]    src_ptr_reg, src_ptr_next;
    logic [PW-1:0]    dst_ptr_reg, dst_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [CW-1:0]    n_reg, n_next;
    logic             src_clip_reg, src_clip_next;
    tbce_pkg::dst_t   dst_reg, dst_next;
    logic             status_reg, status_next;
    logic             wr_pend_reg, wr_pend_next;
    logic [PW-1:0]    wr_addr_reg, wr_addr_next;
    logic [7:0]       rd_char_reg, rd_char_next;

    // Response.
    logic           done_reg, done_next;
    tbce_pkg::rsp_t rsp_reg, rsp_next;

    // Memory ports.
    logic          text_we;
    logic [TA-1:0] text_waddr;
    logic [7:0]    text_wdata;
    logic [7:0]    text_rdata;
    logic          clip_we;
    logic [7:0]    clip_rdata;
    logic [7:0]    copy_data;

    // Setup values worked out from the command and the editor state.
    logic [31:0]    cur_w, len_w, clip_w, tail_w, gap_top_w, req_w, idx_w;
    logic [PW-1:0]  su_src, su_dst;
    logic [CW-1:0]  su_cnt, su_n;
    logic           su_src_clip, su_status;
    tbce_pkg::dst_t su_dst_sel;

    logic accept;

    assign accept = start && !busy;

    // The text is held as a gap buffer: the characters before the cursor sit
    // at the bottom of the text memory, the characters after it at the top,
    // so inserts and cursor moves touch only one or two entries.
    tbce_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_CAP)
    ) u_text_ram (
        .clk   (clk),
        .we    (text_we),
        .waddr (text_waddr),
        .wdata (text_wdata),
        .raddr (src_ptr_reg[TA-1:0]),
        .rdata (text_rdata)
    );

    tbce_ram #(
        .WIDTH (8),
        .DEPTH (CLIP_CAP)
    ) u_clip_ram (
        .clk   (clk),
        .we    (clip_we),
        .waddr (wr_addr_reg[CA-1:0]),
        .wdata (text_rdata),
        .raddr (src_ptr_reg[CA-1:0]),
        .rdata (clip_rdata)
    );

    // ------------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tbce_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tbce_pkg::ST_SETUP;
                end
            end
            tbce_pkg::ST_SETUP:
            begin
                state_next = tbce_pkg::ST_COPY;
            end
            tbce_pkg::ST_COPY:
            begin
                // With nothing left to read, the last write lands this cycle.
                if (cnt_reg == '0)
                begin
                    state_next = tbce_pkg::ST_FINISH;
                end
            end
            tbce_pkg::ST_FINISH:
            begin
                state_next = tbce_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tbce_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Outputs of the sequencer: handshake and memory write ports.
    // ------------------------------------------------------------------------
    always_comb
    begin
        busy      = (state_reg != tbce_pkg::ST_IDLE);
        copy_data = src_clip_reg ? clip_rdata : text_rdata;
        clip_we   = wr_pend_reg && (dst_reg == tbce_pkg::DST_CLIP);
        // A pending copy write and an insert never fall in the same cycle.
        if (wr_pend_reg)
        begin
            text_we    = (dst_reg == tbce_pkg::DST_TEXT);
            text_waddr = wr_addr_reg[TA-1:0];
            text_wdata = copy_data;
        end
        else
        begin
            text_we    = (state_reg == tbce_pkg::ST_FINISH)
                         && (cmd_reg.mode == tbce_pkg::MODE_INSERT)
                         && !status_reg;
            text_waddr = cursor_reg[TA-1:0];
            text_wdata = cmd_reg.char_in;
        end
    end

    // ------------------------------------------------------------------------
    // Setup: turn the command into a copy job (source, destination, count).
    // ------------------------------------------------------------------------
    always_comb
    begin
        cur_w     = 32'(cursor_reg);
        len_w     = 32'(len_reg);
        clip_w    = 32'(clip_reg);
        tail_w    = len_w - cur_w;
        gap_top_w = 32'(TEXT_CAP) - tail_w;
        idx_w     = 32'(cmd_reg.index);
        req_w     = 32'(cmd_reg.count);
        if (req_w > 32'(CLIP_CAP))
        begin
            req_w = 32'(CLIP_CAP);
        end
        if (req_w > tail_w)
        begin
            req_w = tail_w;
        end

        su_src      = '0;
        su_dst      = '0;
        su_cnt      = '0;
        su_n        = '0;
        su_src_clip = 1'b0;
        su_status   = 1'b0;
        su_dst_sel  = tbce_pkg::DST_TEXT;

        case (cmd_reg.mode)
            tbce_pkg::MODE_LEFT:
            begin
                // The character before the cursor moves to the gap's top.
                if (cur_w != 32'd0)
                begin
                    su_src = PW'(cur_w - 32'd1);
                    su_dst = PW'(gap_top_w - 32'd1);
                    su_cnt = CW'(1);
                    su_n   = CW'(1);
                end
            end
            tbce_pkg::MODE_RIGHT:
            begin
                if (tail_w != 32'd0)
                begin
                    su_src = PW'(gap_top_w);
                    su_dst = PW'(cur_w);
                    su_cnt = CW'(1);
                    su_n   = CW'(1);
                end
            end
            tbce_pkg::MODE_INSERT:
            begin
                if (len_w >= 32'(TEXT_CAP))
                begin
                    su_status = 1'b1;
                end
                else
                begin
                    su_n = CW'(1);
                end
            end
            tbce_pkg::MODE_CUT,
            tbce_pkg::MODE_COPY:
            begin
                su_src     = PW'(gap_top_w);
                su_cnt     = CW'(req_w);
                su_n       = CW'(req_w);
                su_dst_sel = tbce_pkg::DST_CLIP;
            end
            tbce_pkg::MODE_PASTE:
            begin
                if (clip_w > 32'(TEXT_CAP) - len_w)
                begin
                    su_status = 1'b1;
                end
                else
                begin
                    su_src_clip = 1'b1;
                    su_dst      = PW'(cur_w);
                    su_cnt      = clip_reg;
                    su_n        = clip_reg;
                end
            end
            tbce_pkg::MODE_READ:
            begin
                // Positions at or past the cursor lie above the gap.
                if (idx_w < len_w)
                begin
                    if (idx_w < cur_w)
                    begin
                        su_src = PW'(idx_w);
                    end
                    else
                    begin
                        su_src = PW'(idx_w + 32'(TEXT_CAP) - len_w);
                    end
                    su_cnt     = CW'(1);
                    su_n       = CW'(1);
                    su_dst_sel = tbce_pkg::DST_RESULT;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath next values.
    // ------------------------------------------------------------------------
    always_comb
    begin
        src_ptr_next  = src_ptr_reg;
        dst_ptr_next  = dst_ptr_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        src_clip_next = src_clip_reg;
        dst_next      = dst_reg;
        status_next   = status_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        rd_char_next  = rd_char_reg;
        cursor_next   = cursor_reg;
        len_next      = len_reg;
        clip_next     = clip_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;

        case (state_reg)
            tbce_pkg::ST_SETUP:
            begin
                src_ptr_next  = su_src;
                dst_ptr_next  = su_dst;
                cnt_next      = su_cnt;
                n_next        = su_n;
                src_clip_next = su_src_clip;
                dst_next      = su_dst_sel;
                status_next   = su_status;
            end
            tbce_pkg::ST_COPY:
            begin
                if (cnt_reg != '0)
                begin
                    src_ptr_next = src_ptr_reg + PW'(1);
                    dst_ptr_next = dst_ptr_reg + PW'(1);
                    cnt_next     = cnt_reg - CW'(1);
                    wr_pend_next = 1'b1;
                    wr_addr_next = dst_ptr_reg;
                end
                if (wr_pend_reg && (dst_reg == tbce_pkg::DST_RESULT))
                begin
                    rd_char_next = text_rdata;
                end
            end
            tbce_pkg::ST_FINISH:
            begin
                case (cmd_reg.mode)
                    tbce_pkg::MODE_LEFT:
                    begin
                        cursor_next = cursor_reg - TW'(n_reg);
                    end
                    tbce_pkg::MODE_RIGHT:
                    begin
                        cursor_next = cursor_reg + TW'(n_reg);
                    end
                    tbce_pkg::MODE_INSERT,
                    tbce_pkg::MODE_PASTE:
                    begin
                        cursor_next = cursor_reg + TW'(n_reg);
                        len_next    = len_reg + TW'(n_reg);
                    end
                    tbce_pkg::MODE_CUT:
                    begin
                        len_next  = len_reg - TW'(n_reg);
                        clip_next = n_reg;
                    end
                    tbce_pkg::MODE_COPY:
                    begin
                        clip_next = n_reg;
                    end
                    default:
                    begin
                    end
                endcase
                done_next            = 1'b1;
                rsp_next.status      = status_reg;
                rsp_next.cursor_pos  = 11'(cursor_next);
                rsp_next.text_length = 11'(len_next);
                rsp_next.clip_length = 9'(clip_next);
                rsp_next.read_valid  = (cmd_reg.mode == tbce_pkg::MODE_READ)
                                       && (n_reg != '0);
                rsp_next.read_char   = rsp_next.read_valid ? rd_char_reg : 8'd0;
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tbce_pkg::ST_IDLE;
            cursor_reg  <= '0;
            len_reg     <= '0;
            clip_reg    <= '0;
            wr_pend_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cursor_reg  <= cursor_next;
            len_reg     <= len_next;
            clip_reg    <= clip_next;
            wr_pend_reg <= wr_pend_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        src_ptr_reg  <= src_ptr_next;
        dst_ptr_reg  <= dst_ptr_next;
        cnt_reg      <= cnt_next;
        n_reg        <= n_next;
        src_clip_reg <= src_clip_next;
        dst_reg      <= dst_next;
        status_reg   <= status_next;
        wr_addr_reg  <= wr_addr_next;
        rd_char_reg  <= rd_char_next;
        rsp_reg      <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    // A response follows only the finishing step of a command.
    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == tbce_pkg::ST_FINISH))
        else $error("response without a finished command");

    // The cursor never passes the end of the text.
    a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= len_reg)
        else $error("cursor beyond text length");

    // The text never outgrows its memory.
    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(len_reg) <= 32'(TEXT_CAP))
        else $error("text length beyond capacity");

    // Clipboard writes come from the copy engine only.
    a_clip_write_in_copy: assert property (@(posedge clk) disable iff (!rst_n)
        clip_we |-> (state_reg == tbce_pkg::ST_COPY))
        else $error("clipboard written outside a copy");

    // An accepted command keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("not busy after accepting a command");
`endif

endmodule

FILE: bench/text_buffer_cursor_editor_top_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// text_buffer_cursor_editor_top_tb: self-checking bench for the text editor
// Drives command beats through the start/busy handshake and checks every
// response beat against a literal from the table or an in-bench model of
// the text, cursor and clipboard. A short directed table comes first, then
// a fill to full capacity and a weighted random mix of all commands.
// ============================================================================
module text_buffer_cursor_editor_top_tb;

    localparam int TEXT_CAP = 1024;
    localparam int CLIP_CAP = 256;
    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 11;

    // The mode field has one code that the block does not use.
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    // The slowest command is a full clipboard paste and a sender gap is rarely
    // long, so reaching this limit with no beat in either direction means the
    // block has hung.
    localparam int WATCHDOG_LIMIT = 2000;

    // Cycles left running after the last response so that a stray response
    // from the slowest possible command would still be caught.
    localparam int TAIL_CYCLES = 300;

    localparam int RANDOM_MIX_ITEMS = 310;

    logic           clk = 1'b0;
    logic           rst_n;
    logic           start;
    tbce_pkg::cmd_t cmd;
    logic           busy;
    logic           done;
    tbce_pkg::rsp_t rsp;

    // One row of the directed table. Where has_literal is set, the response
    // written in the row is what the block must return; otherwise the
    // response comes from the edit model below.
    typedef struct {
        tbce_pkg::cmd_t beat;
        bit             has_literal;
        tbce_pkg::rsp_t literal;
    } edit_row_t;

    edit_row_t directed_rows[$];

    // Responses still owed by the block, oldest first.
    tbce_pkg::rsp_t pending_rsp[$];

    // Model of the editor contents as the block should hold them.
    logic [7:0]  shadow_text [0:TEXT_CAP-1];
    logic [7:0]  shadow_clip [0:CLIP_CAP-1];
    int unsigned shadow_cursor;
    int unsigned shadow_len;
    int unsigned shadow_clip_len;

    int  mismatches;
    int  quiet_cycles;
    bit  sender_idles;

    text_buffer_cursor_editor_top #(
        .TEXT_CAP(TEXT_CAP),
        .CLIP_CAP(CLIP_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .cmd(cmd),
        .busy(busy),
        .done(done),
        .rsp(rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one command to the model and returns the response the block
    // should give for it. Cut and copy take the smallest of the requested
    // count, the clipboard size and the characters right of the cursor.
    function automatic tbce_pkg::rsp_t apply_edit(input tbce_pkg::cmd_t c);
        int unsigned    i;
        int unsigned    take;
        tbce_pkg::rsp_t r;
        r = '0;
        case (c.mode)
            tbce_pkg::MODE_LEFT:
            begin
                if (shadow_cursor > 0)
                    shadow_cursor--;
            end
            tbce_pkg::MODE_RIGHT:
            begin
                if (shadow_cursor < shadow_len)
                    shadow_cursor++;
            end
            tbce_pkg::MODE_INSERT:
            begin
                if (shadow_len >= TEXT_CAP)
                    r.status = 1'b1;
                else
                begin
                    for (i = shadow_len; i > shadow_cursor; i--)
                        shadow_text[i] = shadow_text[i - 1];
                    shadow_text[shadow_cursor] = c.char_in;
                    shadow_cursor++;
                    shadow_len++;
                end
            end
            tbce_pkg::MODE_CUT, tbce_pkg::MODE_COPY:
            begin
                take = c.count;
                if (take > CLIP_CAP)
                    take = CLIP_CAP;
                if (take > shadow_len - shadow_cursor)
                    take = shadow_len - shadow_cursor;
                for (i = 0; i < take; i++)
                    shadow_clip[i] = shadow_text[shadow_cursor + i];
                if (c.mode == tbce_pkg::MODE_CUT)
                begin
                    for (i = shadow_cursor; i + take < shadow_len; i++)
                        shadow_text[i] = shadow_text[i + take];
                    shadow_len -= take;
                end
                shadow_clip_len = take;
            end
            tbce_pkg::MODE_PASTE:
            begin
                if (shadow_clip_len > TEXT_CAP - shadow_len)
                    r.status = 1'b1;
                else
                begin
                    for (i = shadow_len; i > shadow_cursor; i--)
                        shadow_text[i - 1 + shadow_clip_len] = shadow_text[i - 1];
                    for (i = 0; i < shadow_clip_len; i++)
                        shadow_text[shadow_cursor + i] = shadow_clip[i];
                    shadow_cursor += shadow_clip_len;
                    shadow_len += shadow_clip_len;
                end
            end
            tbce_pkg::MODE_READ:
            begin
                if (c.index < shadow_len)
                begin
                    r.read_char = shadow_text[c.index];
                    r.read_valid = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        r.cursor_pos = 11'(shadow_cursor);
        r.text_length = 11'(shadow_len);
        r.clip_length = 9'(shadow_clip_len);
        return r;
    endfunction

    // Presents one command beat and waits for the edge that takes it. The
    // busy value read right after the edge is the one the block saw at that
    // edge, since every signal in the bench and the block changes through
    // nonblocking updates. Start stays high afterwards unless the sender
    // decides to idle, so back-to-back beats never drop start in between.
    task automatic issue(input tbce_pkg::cmd_t c, input bit has_literal,
                         input tbce_pkg::rsp_t literal);
        tbce_pkg::rsp_t predicted;
        cmd <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        predicted = apply_edit(c);
        pending_rsp.insert(pending_rsp.size(), has_literal ? literal : predicted);
        if (sender_idles && $urandom_range(99) < 19)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 60);
        end
    endtask

    task automatic send(input logic [2:0] m, input logic [7:0] ch, input logic [8:0] cnt,
                        input logic [9:0] idx);
        tbce_pkg::cmd_t c;
        c.mode = m;
        c.char_in = ch;
        c.count = cnt;
        c.index = idx;
        issue(c, 1'b0, '0);
    endtask

    // Sends a command whose fields other than mode carry random bits.
    task automatic send_any(input logic [2:0] m);
        send(m, 8'($urandom), 9'($urandom), 10'($urandom));
    endtask

    // Holds start low until every outstanding response has come back.
    task automatic hold_until_drained();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic add_row(input logic [2:0] m, input logic [7:0] ch, input logic [8:0] cnt,
                           input logic [9:0] idx, input bit has_literal,
                           input tbce_pkg::rsp_t literal);
        edit_row_t row;
        row.beat.mode = m;
        row.beat.char_in = ch;
        row.beat.count = cnt;
        row.beat.index = idx;
        row.has_literal = has_literal;
        row.literal = literal;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Response checker and watchdog. Responses are one-cycle strobes that the
    // bench cannot hold off, so each one is checked at the edge that ends it.
    always @(posedge clk)
    begin : rsp_check
        tbce_pkg::rsp_t want;
        if (rst_n && ((start && !busy) || done))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: response beat with nothing outstanding: ",
                              "st=%0d cur=%0d len=%0d clip=%0d rd=%02h rv=%0d"},
                             $realtime, rsp.status, rsp.cursor_pos, rsp.text_length,
                             rsp.clip_length, rsp.read_char, rsp.read_valid);
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status || rsp.cursor_pos !== want.cursor_pos ||
                    rsp.text_length !== want.text_length ||
                    rsp.clip_length !== want.clip_length ||
                    rsp.read_char !== want.read_char || rsp.read_valid !== want.read_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: response mismatch", $realtime);
                        $display("  expected st=%0d cur=%0d len=%0d clip=%0d rd=%02h rv=%0d",
                                 want.status, want.cursor_pos, want.text_length,
                                 want.clip_length, want.read_char, want.read_valid);
                        $display("  actual   st=%0d cur=%0d len=%0d clip=%0d rd=%02h rv=%0d",
                                 rsp.status, rsp.cursor_pos, rsp.text_length,
                                 rsp.clip_length, rsp.read_char, rsp.read_valid);
                    end
                end
            end
        end

        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          k;
        int          pick;
        logic [9:0]  idx;
        logic [8:0]  cnt;

        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        mismatches = 0;
        quiet_cycles = 0;
        sender_idles = 1'b1;
        shadow_cursor = 0;
        shadow_len = 0;
        shadow_clip_len = 0;

        // Directed table. The first rows run on the empty editor, where every
        // command but insert must leave all counters at zero; the literal
        // responses below follow directly from that.
        add_row(tbce_pkg::MODE_READ,   8'h00, 9'h000, 10'd0,   1'b1,
                {1'b0, 11'd0, 11'd0, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_LEFT,   8'hFF, 9'h1FF, 10'h3FF, 1'b1,
                {1'b0, 11'd0, 11'd0, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_RIGHT,  8'h00, 9'h000, 10'h000, 1'b1,
                {1'b0, 11'd0, 11'd0, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_CUT,    8'h55, 9'h1FF, 10'h155, 1'b1,
                {1'b0, 11'd0, 11'd0, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_COPY,   8'hAA, 9'd256, 10'h2AA, 1'b1,
                {1'b0, 11'd0, 11'd0, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_PASTE,  8'h0F, 9'h0F0, 10'h0F0, 1'b1,
                {1'b0, 11'd0, 11'd0, 9'd0, 8'h00, 1'b0});
        add_row(MODE_UNUSED,           8'hFF, 9'h1FF, 10'h3FF, 1'b1,
                {1'b0, 11'd0, 11'd0, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_INSERT, 8'hFF, 9'h000, 10'h000, 1'b1,
                {1'b0, 11'd1, 11'd1, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_INSERT, 8'h00, 9'h1FF, 10'h3FF, 1'b1,
                {1'b0, 11'd2, 11'd2, 9'd0, 8'h00, 1'b0});
        // A read past the text gives zero data and a clear valid flag.
        add_row(tbce_pkg::MODE_READ,   8'hFF, 9'h1FF, 10'h3FF, 1'b1,
                {1'b0, 11'd2, 11'd2, 9'd0, 8'h00, 1'b0});
        add_row(tbce_pkg::MODE_READ,   8'h00, 9'h000, 10'd0,   1'b1,
                {1'b0, 11'd2, 11'd2, 9'd0, 8'hFF, 1'b1});
        add_row(tbce_pkg::MODE_INSERT, 8'h5A, 9'h000, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_RIGHT,  8'h00, 9'h000, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_LEFT,   8'h00, 9'h000, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_LEFT,   8'h00, 9'h000, 10'h000, 1'b0, '0);
        // Copy near the end of the text takes only what is right of the cursor.
        add_row(tbce_pkg::MODE_COPY,   8'h00, 9'd256, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_PASTE,  8'h00, 9'h000, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_READ,   8'h00, 9'h000, 10'd4,   1'b0, '0);
        add_row(tbce_pkg::MODE_CUT,    8'h00, 9'd1,   10'h000, 1'b0, '0);
        // A cut of zero characters still replaces the clipboard.
        add_row(tbce_pkg::MODE_CUT,    8'h00, 9'd0,   10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_PASTE,  8'h00, 9'h000, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_LEFT,   8'h00, 9'h000, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_COPY,   8'h00, 9'h1FF, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_INSERT, 8'h80, 9'h000, 10'h000, 1'b0, '0);
        add_row(tbce_pkg::MODE_READ,   8'h00, 9'h000, 10'd2,   1'b0, '0);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < directed_rows.size(); k++)
            issue(directed_rows[k].beat, directed_rows[k].has_literal,
                  directed_rows[k].literal);

        // Fill to capacity. Only left moves put characters right of the
        // cursor, so a short run of inserts and lefts seeds sixteen of them,
        // pastes of that run grow the text, and a long walk left leaves at
        // least a full clipboard's worth right of the cursor.
        repeat (16)
            send_any(tbce_pkg::MODE_INSERT);
        repeat (16)
            send_any(tbce_pkg::MODE_LEFT);
        send(tbce_pkg::MODE_COPY, 8'($urandom), 9'd16, 10'($urandom));
        while (shadow_len < 300)
            send_any(tbce_pkg::MODE_PASTE);
        repeat (260)
            send_any(tbce_pkg::MODE_LEFT);
        // Count at or above the clipboard size saturates to a full clipboard.
        send(tbce_pkg::MODE_COPY, 8'($urandom), 9'($urandom_range(256, 511)),
             10'($urandom));
        while (shadow_len < TEXT_CAP)
        begin
            if (TEXT_CAP - shadow_len < shadow_clip_len)
                send(tbce_pkg::MODE_COPY, 8'($urandom), 9'(TEXT_CAP - shadow_len),
                     10'($urandom));
            send_any(tbce_pkg::MODE_PASTE);
        end

        // Text full: insert and a non-empty paste must both be dropped.
        send_any(tbce_pkg::MODE_INSERT);
        send_any(tbce_pkg::MODE_PASTE);
        send(tbce_pkg::MODE_READ, 8'($urandom), 9'($urandom), 10'h3FF);

        // A cut followed by a paste keeps the length and moves the cursor
        // right by the cut size, which walks the cursor to the far end.
        while (shadow_cursor < shadow_len)
        begin
            send(tbce_pkg::MODE_CUT, 8'($urandom), 9'h1FF, 10'($urandom));
            send_any(tbce_pkg::MODE_PASTE);
        end
        send_any(tbce_pkg::MODE_RIGHT);
        send_any(tbce_pkg::MODE_INSERT);
        send(tbce_pkg::MODE_CUT, 8'($urandom), 9'd5, 10'($urandom));
        // An empty clipboard fits even into a full text.
        send_any(tbce_pkg::MODE_PASTE);
        repeat (40)
            send_any(tbce_pkg::MODE_LEFT);
        send(tbce_pkg::MODE_CUT, 8'($urandom), 9'h1FF, 10'($urandom));

        hold_until_drained();

        // Weighted random mix. Cuts outweigh pastes so that the length wanders
        // down from full; reads mostly land inside the text.
        for (k = 0; k < RANDOM_MIX_ITEMS; k++)
        begin
            sender_idles = !(k >= 100 && k < 220);
            pick = $urandom_range(99);
            if ($urandom_range(1))
                cnt = 9'($urandom_range(0, 32));
            else
                cnt = 9'($urandom_range(0, 511));
            if (shadow_len != 0 && $urandom_range(3) != 0)
                idx = 10'($urandom_range(shadow_len - 1));
            else
                idx = 10'($urandom);
            if (pick < 20)
                send_any(tbce_pkg::MODE_LEFT);
            else if (pick < 30)
                send_any(tbce_pkg::MODE_RIGHT);
            else if (pick < 45)
                send_any(tbce_pkg::MODE_INSERT);
            else if (pick < 60)
                send(tbce_pkg::MODE_CUT, 8'($urandom), cnt, 10'($urandom));
            else if (pick < 70)
                send(tbce_pkg::MODE_COPY, 8'($urandom), cnt, 10'($urandom));
            else if (pick < 78)
                send_any(tbce_pkg::MODE_PASTE);
            else if (pick < 95)
                send(tbce_pkg::MODE_READ, 8'($urandom), 9'($urandom), idx);
            else
                send_any(MODE_UNUSED);
            if ($urandom_range(99) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
